@@ sv/adc_thermistor_temperature_macros.svh @@
// Assertion macros used by the checker of the thermistor temperature block.
`ifndef ADC_THERMISTOR_TEMPERATURE_MACROS_SVH
`define ADC_THERMISTOR_TEMPERATURE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/adctt_pkg.sv @@
// Types, constants and the thermistor curve for the ADC temperature block.
package adctt_pkg;

    localparam int CODE_W            = 12;
    localparam int CODE_TO_V         = 225;     // code * 225 = voltage in 1/512 mV
    localparam int V_W               = 20;
    localparam int TBL_W             = 17;      // curve entries in 1/32 mV
    localparam int TBL_IDX_W         = 7;       // covers up to 64 entries plus the end mark
    localparam int CURVE_POINTS      = 34;
    localparam int TABLE_ENTRIES_DEF = 34;
    localparam int STEP_Q8           = 1280;    // 5 C in 1/256 C
    localparam int MIN_TEMP_Q8       = -10240;  // -40 C
    localparam int NUM_SCALE         = STEP_Q8 / 16;
    localparam int NUM_W             = 27;
    localparam int GAP_W             = 11;      // quotient never exceeds STEP_Q8
    localparam int TEMP_W            = 19;
    localparam int OUT_W             = 16;
    localparam int OUT_MAX           = 32767;
    localparam int OUT_MIN           = -32768;

    localparam logic [TBL_W-1:0] CURVE_Q5 [CURVE_POINTS] = '{
        17'd54923, 17'd54105, 17'd53096, 17'd51879, 17'd50433, 17'd48748, 17'd46821,
        17'd44665, 17'd42297, 17'd39750, 17'd37072, 17'd34318, 17'd31548, 17'd28800,
        17'd26140, 17'd23599, 17'd21209, 17'd18984, 17'd16936, 17'd15069, 17'd13384,
        17'd11868, 17'd10514, 17'd9314,  17'd8251,  17'd7299,  17'd6450,  17'd5694,
        17'd5027,  17'd4442,  17'd3927,  17'd3475,  17'd3080,  17'd2735
    };

    typedef struct packed {
        logic [TEMP_W-1:0] base;   // step temperature before the interpolation term
        logic              below;
        logic              above;
        logic              hold;   // drop the quotient: out of range or flat segment
    } meta_t;

    // Entries past the curve read as zero.
    function automatic logic [TBL_W-1:0] table_entry(input logic [TBL_IDX_W-1:0] i);
        logic [TBL_W-1:0] e;
        e = '0;
        if (i < TBL_IDX_W'(CURVE_POINTS)) begin
            e = CURVE_Q5[i[TBL_IDX_W-2:0]];
        end
        return e;
    endfunction

endpackage

@@ sv/adc_thermistor_temperature.sv @@
// Thermistor temperature from a 12-bit ADC code: pipelined table search and interpolation.
// Throughput: one beat per cycle; a binary-search stage per index bit and a restoring
// divide stage per quotient bit, all advancing together.
// A stall at the output holds every stage and drops s_tready in the same cycle.
// aresetn (synchronous, active low) clears all valid bits; the curve is a constant table.
module adc_thermistor_temperature #(
    parameter int TABLE_ENTRIES = adctt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] temperature_q8
    output logic [1:0]  m_tuser    // [0] below_range, [1] above_range
);
    import adctt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic signed [TEMP_W-1:0] SAT_HI = TEMP_W'(OUT_MAX);
    localparam logic signed [TEMP_W-1:0] SAT_LO = TEMP_W'(OUT_MIN);

    logic advance;

    // search pipeline
    logic             srch_valid_reg [IDX_W+1];
    logic [V_W-1:0]   srch_v_reg     [IDX_W+1];
    logic [IDX_W-1:0] srch_idx_reg   [IDX_W+1];
    logic [V_W-1:0]   srch_v_next    [IDX_W+1];
    logic [IDX_W-1:0] srch_idx_next  [IDX_W+1];

    // segment fetch
    logic             fetch_valid_reg;
    logic [V_W-1:0]   fetch_x_reg,   fetch_x_next;
    logic [TBL_W-1:0] fetch_d_reg,   fetch_d_next;
    meta_t            fetch_meta_reg, fetch_meta_next;
    logic [TBL_W-1:0] seg_hi, seg_lo;
    logic [IDX_W-1:0] idx_sel;
    logic             idx_below, idx_above;

    // divider pipeline
    logic             div_valid_reg [GAP_W+1];
    logic [NUM_W-1:0] div_rem_reg   [GAP_W+1];
    logic [TBL_W-1:0] div_den_reg   [GAP_W+1];
    logic [GAP_W-1:0] div_q_reg     [GAP_W+1];
    meta_t            div_meta_reg  [GAP_W+1];
    logic [NUM_W-1:0] div_rem_next  [GAP_W+1];
    logic [GAP_W-1:0] div_q_next    [GAP_W+1];

    // output
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;
    logic [GAP_W-1:0] gap;
    logic signed [TEMP_W-1:0] temp_full;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Binary search for the first entry strictly below v. The curve falls, so the
    // index equals the count of leading entries with v <= 16*t; one index bit per stage.
    always_comb begin
        srch_v_next[0]   = V_W'(s_tdata[CODE_W-1:0]) * V_W'(CODE_TO_V);
        srch_idx_next[0] = '0;
        for (int k = 0; k < IDX_W; k++) begin
            logic [IDX_W-1:0] cand;
            cand = srch_idx_reg[k] | (IDX_W'(1) << (IDX_W - 1 - k));
            srch_v_next[k+1]   = srch_v_reg[k];
            srch_idx_next[k+1] = srch_idx_reg[k];
            // entry scaled by 16 into 1/512 mV
            if ((cand <= IDX_W'(TABLE_ENTRIES)) &&
                ({1'b0, srch_v_reg[k]} <=
                 {table_entry(TBL_IDX_W'(cand - IDX_W'(1))), 4'b0000})) begin
                srch_idx_next[k+1] = cand;
            end
        end
    end

    always_comb begin
        idx_below = (srch_idx_reg[IDX_W] == '0);
        idx_above = (srch_idx_reg[IDX_W] == IDX_W'(TABLE_ENTRIES));
        seg_hi    = table_entry(TBL_IDX_W'(srch_idx_reg[IDX_W] - IDX_W'(1)));
        seg_lo    = table_entry(TBL_IDX_W'(srch_idx_reg[IDX_W]));
        idx_sel   = idx_above ? IDX_W'(TABLE_ENTRIES - 1) : srch_idx_reg[IDX_W];
        fetch_x_next         = srch_v_reg[IDX_W] - V_W'({seg_lo, 4'b0000});
        fetch_d_next         = seg_hi - seg_lo;
        fetch_meta_next.base = TEMP_W'(idx_sel) * TEMP_W'(STEP_Q8) + TEMP_W'(MIN_TEMP_Q8);
        fetch_meta_next.below = idx_below;
        fetch_meta_next.above = idx_above;
        fetch_meta_next.hold  = idx_below || idx_above || (seg_hi <= seg_lo);
    end

    // Restoring divide of 80*x by d, one quotient bit per stage, MSB first.
    always_comb begin
        div_rem_next[0] = NUM_W'(fetch_x_reg) * NUM_W'(NUM_SCALE);
        div_q_next[0]   = '0;
        for (int k = 0; k < GAP_W; k++) begin
            logic [NUM_W-1:0] trial;
            trial = NUM_W'(div_den_reg[k]) << (GAP_W - 1 - k);
            div_rem_next[k+1] = div_rem_reg[k];
            div_q_next[k+1]   = div_q_reg[k];
            if (div_rem_reg[k] >= trial) begin
                div_rem_next[k+1] = div_rem_reg[k] - trial;
                div_q_next[k+1]   = div_q_reg[k] | (GAP_W'(1) << (GAP_W - 1 - k));
            end
        end
    end

    always_comb begin
        gap       = div_meta_reg[GAP_W].hold ? '0 : div_q_reg[GAP_W];
        temp_full = signed'(div_meta_reg[GAP_W].base - TEMP_W'(gap));
        m_tdata_next = OUT_W'(temp_full);
        if (temp_full > SAT_HI) begin
            m_tdata_next = OUT_W'(SAT_HI);
        end else if (temp_full < SAT_LO) begin
            m_tdata_next = OUT_W'(SAT_LO);
        end
        m_tuser_next = {div_meta_reg[GAP_W].above, div_meta_reg[GAP_W].below};
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= IDX_W; k++) begin
                srch_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= GAP_W; k++) begin
                div_valid_reg[k] <= 1'b0;
            end
            fetch_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else if (advance) begin
            srch_valid_reg[0] <= s_tvalid;
            for (int k = 0; k < IDX_W; k++) begin
                srch_valid_reg[k+1] <= srch_valid_reg[k];
            end
            fetch_valid_reg  <= srch_valid_reg[IDX_W];
            div_valid_reg[0] <= fetch_valid_reg;
            for (int k = 0; k < GAP_W; k++) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
            m_tvalid_reg <= div_valid_reg[GAP_W];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k <= IDX_W; k++) begin
                srch_v_reg[k]   <= srch_v_next[k];
                srch_idx_reg[k] <= srch_idx_next[k];
            end
            fetch_x_reg    <= fetch_x_next;
            fetch_d_reg    <= fetch_d_next;
            fetch_meta_reg <= fetch_meta_next;
            div_den_reg[0]  <= fetch_d_reg;
            div_meta_reg[0] <= fetch_meta_reg;
            for (int k = 0; k <= GAP_W; k++) begin
                div_rem_reg[k] <= div_rem_next[k];
                div_q_reg[k]   <= div_q_next[k];
            end
            for (int k = 0; k < GAP_W; k++) begin
                div_den_reg[k+1]  <= div_den_reg[k];
                div_meta_reg[k+1] <= div_meta_reg[k];
            end
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

@@ sv/adctt_checker.sv @@
// Port-level checker for the thermistor temperature block, bound to the top level.
`include "adc_thermistor_temperature_macros.svh"

module adctt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import adctt_pkg::*;

    localparam logic [OUT_W-1:0] LOW_TEMP = OUT_W'(MIN_TEMP_Q8);

    `ATT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
    `ATT_ASSERT_NOW(a_flags_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]), "both range flags set")
    `ATT_ASSERT_NOW(a_below_temp, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == LOW_TEMP, "below range beat not at -40 C")
    `ATT_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind adc_thermistor_temperature adctt_checker u_adctt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/adc_thermistor_temperature_tb.sv @@
// Self-checking testbench for the ADC thermistor temperature block: random and corner codes.
`timescale 1ns / 100ps

module adc_thermistor_temperature_tb;

    import adctt_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_CODES = 1000;
    localparam int DRAIN_CYCLES = 40;      // comfortably above the pipeline depth
    localparam int STALL_AFTER  = 300;     // codes taken before the long output stall
    localparam int STALL_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic signed [OUT_W-1:0] temperature_q8;
        logic                    below_range;
        logic                    above_range;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [CODE_W-1:0] code_queue[$];
    reading_t          expected_readings[$];
    logic              code_beat_taken;
    int                codes_total;
    int                codes_taken;
    int                error_count;
    int                cycle_count;
    int                stall_left;
    bit                stall_done;

    adc_thermistor_temperature uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Curve entry scaled into the 1/512 mV voltage domain; entries past the curve are zero.
    function automatic longint curve_volts(input int idx);
        longint e;
        e = 0;
        if (idx < CURVE_POINTS) begin
            e = longint'(CURVE_Q5[idx]) * 16;
        end
        return e;
    endfunction

    function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
        longint   volt;
        longint   lo;
        longint   hi;
        longint   gap;
        longint   temp;
        int       seg;
        int       i;
        reading_t r;
        volt = longint'(code) * CODE_TO_V;
        seg = -1;
        for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            if (seg < 0 && volt > curve_volts(i)) begin
                seg = i;
            end
        end
        r.below_range = 1'b0;
        r.above_range = 1'b0;
        if (seg < 0) begin
            temp = MIN_TEMP_Q8 + STEP_Q8 * (TABLE_ENTRIES_DEF - 1);
            r.above_range = 1'b1;
        end else if (seg == 0) begin
            temp = MIN_TEMP_Q8;
            r.below_range = 1'b1;
        end else begin
            lo = curve_volts(seg);
            hi = curve_volts(seg - 1);
            gap = 0;
            if (hi > lo && volt >= lo) begin
                gap = (STEP_Q8 * (volt - lo)) / (hi - lo);
            end
            temp = MIN_TEMP_Q8 + STEP_Q8 * seg - gap;
        end
        if (temp > OUT_MAX) temp = OUT_MAX;
        if (temp < OUT_MIN) temp = OUT_MIN;
        r.temperature_q8 = temp[OUT_W-1:0];
        return r;
    endfunction

    // Idle percentages per third of the run: sender light/receiver heavy, swapped, then none.
    function automatic int send_idle_pct(input int taken);
        int phase;
        phase = (taken * 3) / codes_total;
        return (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
    endfunction

    function automatic int recv_idle_pct(input int taken);
        int phase;
        phase = (taken * 3) / codes_total;
        return (phase == 0) ? 61 : (phase == 1) ? 6 : 0;
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        int sel;
        int edge_code;
        sel = $urandom_range(99);
        if (sel < 70) begin
            return CODE_W'($urandom_range(4095));
        end else if (sel < 85) begin
            // flag regions: below 195 saturates high, above 3905 holds at -40 C
            if ($urandom_range(1)) return CODE_W'($urandom_range(210));
            return CODE_W'($urandom_range(4095, 3890));
        end
        // straddle a table knee
        edge_code = int'(curve_volts($urandom_range(CURVE_POINTS - 1)) / CODE_TO_V)
                    + $urandom_range(2) - 1;
        if (edge_code < 0) edge_code = 0;
        if (edge_code > 4095) edge_code = 4095;
        return CODE_W'(edge_code);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Input side: predict on every accepted beat.
    always @(posedge aclk) begin
        code_beat_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_readings.push_back(predict_reading(s_tdata[CODE_W-1:0]));
            codes_taken = codes_taken + 1;
        end
    end

    // Driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || code_beat_taken)) begin
            if (code_queue.size() != 0 && $urandom_range(99) >= send_idle_pct(codes_taken)) begin
                s_tdata  <= {{(16 - CODE_W){1'b0}}, code_queue.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure plus one long hold-off to fill the pipeline
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (!stall_done && codes_taken >= STALL_AFTER) begin
                stall_done <= 1'b1;
                stall_left <= STALL_CYCLES;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct(codes_taken));
            end
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected result beat: temperature_q8=%0d tuser=%b",
                       $signed(m_tdata), m_tuser);
                error_count = error_count + 1;
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata !== want.temperature_q8) begin
                    $error("temperature_q8: expected %0d, got %0d",
                           want.temperature_q8, $signed(m_tdata));
                    error_count = error_count + 1;
                end
                if (m_tuser[0] !== want.below_range) begin
                    $error("below_range: expected %0b, got %0b", want.below_range, m_tuser[0]);
                    error_count = error_count + 1;
                end
                if (m_tuser[1] !== want.above_range) begin
                    $error("above_range: expected %0b, got %0b", want.above_range, m_tuser[1]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] corner_codes[$];
        int n;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        code_beat_taken = 1'b0;
        codes_taken     = 0;
        error_count     = 0;
        cycle_count     = 0;
        stall_left      = 0;
        stall_done      = 1'b0;

        // extremes, both flag edges, an exact knee hit (2048 -> 28800), bit patterns
        corner_codes = '{12'd0, 12'd4095, 12'd1, 12'd194, 12'd195, 12'd219, 12'd220,
                         12'd3847, 12'd3848, 12'd3905, 12'd3906, 12'd3907, 12'd2047,
                         12'd2048, 12'd2049, 12'hAAA, 12'h555, 12'hFFE, 12'h001,
                         12'h800, 12'h7FF, 12'd1000, 12'd3000};
        code_queue = corner_codes;
        for (n = 0; n < RANDOM_CODES; n++) begin
            code_queue.push_back(random_code());
        end
        codes_total = code_queue.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (code_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_readings.size() != 0) begin
            $error("%0d results never arrived", expected_readings.size());
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
